// ===== hw/rtl/wsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants of the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    typedef logic [1:0]  t_kind;
    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_opcode;
    typedef logic [23:0] t_len;

    // result kinds
    localparam t_kind KIND_PAYLOAD   = 2'd0;
    localparam t_kind KIND_EMPTY     = 2'd1;
    localparam t_kind KIND_TOO_LARGE = 2'd2;

    localparam t_opcode OPC_CLOSE    = 4'h8;

    // 7-bit length escapes in header byte 1
    localparam logic [6:0] LEN_ESC16 = 7'd126;
    localparam logic [6:0] LEN_ESC64 = 7'd127;

    localparam t_len LEN_MAX         = 24'hFF_FFFF;
    localparam t_len MAX_FRAME_RESET = 24'd8192;

    typedef struct packed {
        t_kind   kind;
        t_byte   data;
        t_opcode frame_opcode;
        t_len    frame_length;
        logic    last;
    } t_result;

endpackage

// ===== hw/rtl/wsfp_ifs.sv =====
// ----------------------------------------------------------------------------
// wsfp channel interfaces
// Valid/ready channels for received bytes, results and the limit register.
// ----------------------------------------------------------------------------
interface wsfp_byte_if;
    import wsfp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfp_res_if;
    import wsfp_pkg::*;

    logic    valid;
    logic    ready;
    t_kind   kind;
    t_byte   data;
    t_opcode frame_opcode;
    t_len    frame_length;
    logic    last;

    modport source (output valid, output kind, output data, output frame_opcode,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input kind, input data, input frame_opcode,
                    input frame_length, input last, output ready);
endinterface

interface wsfp_cfg_if;
    import wsfp_pkg::*;

    logic valid;
    logic ready;
    t_len max_frame_bytes;

    modport source (output valid, output max_frame_bytes, input ready);
    modport sink   (input valid, input max_frame_bytes, output ready);
endinterface

// ===== hw/rtl/wsfp_skid.sv =====
// ----------------------------------------------------------------------------
// wsfp_skid
// Two-entry input register; ready depends only on local state.
// ----------------------------------------------------------------------------
module wsfp_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  wsfp_pkg::t_byte i_byte,
    output logic           o_ready,
    output logic           o_hd_valid,
    output wsfp_pkg::t_byte o_hd_byte,
    input  logic           i_adv
);
    import wsfp_pkg::*;

    logic  r_hd_valid;
    t_byte r_hd_byte;
    logic  r_sk_valid;
    t_byte r_sk_byte;
    logic  w_push;

    assign o_ready    = !r_sk_valid;
    assign w_push     = i_valid && !r_sk_valid;
    assign o_hd_valid = r_hd_valid;
    assign o_hd_byte  = r_hd_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (i_adv) begin
            if (r_sk_valid) begin
                r_hd_valid <= 1'b1;
                r_hd_byte  <= r_sk_byte;
                r_sk_valid <= 1'b0;
            end else begin
                r_hd_valid <= w_push;
                r_hd_byte  <= i_byte;
            end
        end else if (w_push) begin
            if (!r_hd_valid) begin
                r_hd_valid <= 1'b1;
                r_hd_byte  <= i_byte;
            end else begin
                r_sk_valid <= 1'b1;
                r_sk_byte  <= i_byte;
            end
        end
    end

endmodule

// ===== hw/rtl/wsfp_deframe.sv =====
// ----------------------------------------------------------------------------
// wsfp_deframe
// Header state machine, size check and payload unmasking for one byte.
// ----------------------------------------------------------------------------
module wsfp_deframe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  wsfp_pkg::t_byte   i_byte,
    input  wsfp_pkg::t_len    i_max,
    output logic              o_res_valid,
    output wsfp_pkg::t_result o_res
);
    import wsfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_ext_left, n_ext_left;
    t_len        r_len_lo, n_len_lo;
    logic        r_len_ovf, n_len_ovf;   // some bit above 23 of the length is set
    logic        r_masked, n_masked;
    logic [31:0] r_key, n_key;
    t_len        r_idx, n_idx;
    t_opcode     r_opcode, n_opcode;
    logic [3:0]  r_hdr_len, n_hdr_len;
    logic        r_closed, n_closed;

    always_comb begin
        logic        v_ld;
        logic        v_hd;
        logic [24:0] v_sum;
        t_byte       v_key_byte;

        n_phase     = r_phase;
        n_ext_left  = r_ext_left;
        n_len_lo    = r_len_lo;
        n_len_ovf   = r_len_ovf;
        n_masked    = r_masked;
        n_key       = r_key;
        n_idx       = r_idx;
        n_opcode    = r_opcode;
        n_hdr_len   = r_hdr_len;
        n_closed    = r_closed;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, data: '0, frame_opcode: r_opcode,
                        frame_length: r_len_lo, last: 1'b0};
        v_ld        = 1'b0;
        v_hd        = 1'b0;
        v_sum       = '0;
        v_key_byte  = '0;

        if (i_adv && !r_closed) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked  = i_byte[7];
                    n_len_ovf = 1'b0;
                    if (i_byte[6:0] == LEN_ESC16) begin
                        n_len_lo   = '0;
                        n_ext_left = 4'd2;
                        n_hdr_len  = 4'd4;
                        n_phase    = PH_EXT;
                    end else if (i_byte[6:0] == LEN_ESC64) begin
                        n_len_lo   = '0;
                        n_ext_left = 4'd8;
                        n_hdr_len  = 4'd10;
                        n_phase    = PH_EXT;
                    end else begin
                        n_len_lo  = {17'd0, i_byte[6:0]};
                        n_hdr_len = 4'd2;
                        v_ld      = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_len_lo   = {r_len_lo[15:0], i_byte};
                    n_len_ovf  = r_len_ovf || (r_len_lo[23:16] != 8'd0);
                    n_ext_left = r_ext_left - 4'd1;
                    v_ld       = (n_ext_left == 4'd0);
                end
                PH_MASK: begin
                    n_key      = {r_key[23:0], i_byte};
                    n_ext_left = r_ext_left - 4'd1;
                    v_hd       = (n_ext_left == 4'd0);
                end
                PH_PAY: begin
                    case (r_idx[1:0])
                        2'd0:    v_key_byte = r_key[31:24];
                        2'd1:    v_key_byte = r_key[23:16];
                        2'd2:    v_key_byte = r_key[15:8];
                        default: v_key_byte = r_key[7:0];
                    endcase
                    n_idx       = r_idx + t_len'(1);
                    o_res_valid = 1'b1;
                    o_res.data  = i_byte ^ v_key_byte;
                    if (n_idx >= r_len_lo) begin
                        o_res.last = 1'b1;
                        n_phase    = PH_HDR0;
                        if (r_opcode == OPC_CLOSE) begin
                            n_closed = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // length complete: mask key next, or header done
            if (v_ld) begin
                n_key = '0;
                if (n_masked) begin
                    n_hdr_len  = n_hdr_len + 4'd4;
                    n_ext_left = 4'd4;
                    n_phase    = PH_MASK;
                end else begin
                    v_hd = 1'b1;
                end
            end

            if (v_hd) begin
                v_sum = {1'b0, n_len_lo} + {21'd0, n_hdr_len};
                n_idx = '0;
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                n_phase     = PH_HDR0;
                if (n_len_ovf || (v_sum > {1'b0, i_max})) begin
                    o_res.kind         = KIND_TOO_LARGE;
                    o_res.frame_length = n_len_ovf ? LEN_MAX : n_len_lo;
                    n_closed           = 1'b1;
                end else if (n_len_lo == '0) begin
                    o_res.kind         = KIND_EMPTY;
                    o_res.frame_length = '0;
                    if (r_opcode == OPC_CLOSE) begin
                        n_closed = 1'b1;
                    end
                end else begin
                    o_res_valid = 1'b0;
                    o_res.last  = 1'b0;
                    n_phase     = PH_PAY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_ext_left <= '0;
            r_len_lo   <= '0;
            r_len_ovf  <= 1'b0;
            r_masked   <= 1'b0;
            r_key      <= '0;
            r_idx      <= '0;
            r_opcode   <= '0;
            r_hdr_len  <= '0;
            r_closed   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_len_lo   <= n_len_lo;
            r_len_ovf  <= n_len_ovf;
            r_masked   <= n_masked;
            r_key      <= n_key;
            r_idx      <= n_idx;
            r_opcode   <= n_opcode;
            r_hdr_len  <= n_hdr_len;
            r_closed   <= n_closed;
        end
    end

endmodule

// ===== hw/rtl/websocket_frame_parser.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Byte-serial WebSocket frame deframer with size limit and unmasking.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and gives at most one result word per byte:
// each unmasked payload byte, one word for a frame with no payload, or one
// error word when header plus payload exceeds max_frame_bytes (reset 8192).
// A byte is held in a two-entry input register, processed by the header
// state machine and written to the result register, from which its result
// is shown; one byte per cycle is sustained as long as results are taken.
// After an error or a finished close frame every byte is taken and dropped
// until reset. Write the limit only while idle.
module websocket_frame_parser (
    input  logic    i_clk,
    input  logic    i_rst_n,
    wsfp_byte_if.sink i_rx,
    wsfp_cfg_if.sink  i_cfg,
    wsfp_res_if.source o_res
);
    import wsfp_pkg::*;

    t_len    r_max;
    logic    w_hd_valid;
    t_byte   w_hd_byte;
    logic    w_adv;
    logic    w_res_valid;
    t_result w_res;
    logic    r_out_valid;
    t_result r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_FRAME_RESET;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.max_frame_bytes;
        end
    end

    assign w_adv = w_hd_valid && (!r_out_valid || o_res.ready);

    wsfp_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_rx.valid),
        .i_byte     (i_rx.rx_byte),
        .o_ready    (i_rx.ready),
        .o_hd_valid (w_hd_valid),
        .o_hd_byte  (w_hd_byte),
        .i_adv      (w_adv)
    );

    wsfp_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_byte      (w_hd_byte),
        .i_max       (r_max),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid <= w_adv && w_res_valid;
            r_out       <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.data         = r_out.data;
    assign o_res.frame_opcode = r_out.frame_opcode;
    assign o_res.frame_length = r_out.frame_length;
    assign o_res.last         = r_out.last;

    // a full skid entry means the head entry is occupied as well
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> w_hd_valid)
        else $error("input skid entry full while head entry empty");

    // the error closes the stream, so nothing follows it
    a_quiet_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.kind == KIND_TOO_LARGE) |=> !o_res.valid)
        else $error("result word after frame size error");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_TOO_LARGE || o_res.kind == KIND_EMPTY))
        |-> (o_res.last && o_res.data == 8'd0))
        else $error("empty or error word not marked last with zero data");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.kind == KIND_PAYLOAD || o_res.kind == KIND_EMPTY
                         || o_res.kind == KIND_TOO_LARGE))
        else $error("result word with unknown kind");

endmodule

// ===== tb/websocket_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_checker
// Watches the byte, result and limit channels, deframes the accepted bytes
// on its own and compares every accepted result word with the oldest one due.
// ----------------------------------------------------------------------------
module websocket_frame_parser_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wsfp_byte_if   i_rx,
    wsfp_res_if    i_res,
    wsfp_cfg_if    i_cfg,
    output int     o_fail_count,
    output int     o_pending
);
    import wsfp_pkg::*;

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_EXT,
        ST_KEY,
        ST_PAYLOAD
    } t_phase;

    t_phase      st;
    logic [3:0]  ext_left;
    logic [63:0] pay_len;
    logic        masked;
    logic [31:0] key;
    t_len        idx;
    t_opcode     opc;
    logic [3:0]  hdr_len;
    logic        closed;
    t_len        limit;
    t_result     due_q[$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic void push_word(t_kind k, t_byte d, logic [63:0] len, logic lst);
        t_result r;
        r.kind         = k;
        r.data         = d;
        r.frame_opcode = opc;
        r.frame_length = (len > {40'd0, LEN_MAX}) ? LEN_MAX : len[23:0];
        r.last         = lst;
        due_q.push_back(r);
    endfunction

    // header complete: size check, then payload or empty frame
    function automatic void header_check();
        if ({1'b0, pay_len} + 65'(hdr_len) > {41'd0, limit}) begin
            push_word(KIND_TOO_LARGE, 8'h00, pay_len, 1'b1);
            closed = 1'b1;
            st = ST_HDR0;
        end else begin
            idx = '0;
            if (pay_len == 64'd0) begin
                push_word(KIND_EMPTY, 8'h00, 64'd0, 1'b1);
                if (opc == OPC_CLOSE)
                    closed = 1'b1;
                st = ST_HDR0;
            end else begin
                st = ST_PAYLOAD;
            end
        end
    endfunction

    function automatic void length_known();
        key = '0;
        if (masked) begin
            hdr_len  = hdr_len + 4'd4;
            ext_left = 4'd4;
            st = ST_KEY;
        end else begin
            header_check();
        end
    endfunction

    function automatic void deframe_byte(t_byte b);
        int    lane;
        t_byte d;
        if (closed)
            return;
        case (st)
            ST_HDR0: begin
                opc = b[3:0];
                st = ST_HDR1;
            end
            ST_HDR1: begin
                masked  = b[7];
                hdr_len = 4'd2;
                pay_len = '0;
                if (b[6:0] == LEN_ESC16 || b[6:0] == LEN_ESC64) begin
                    ext_left = (b[6:0] == LEN_ESC16) ? 4'd2 : 4'd8;
                    hdr_len  = hdr_len + ext_left;
                    st = ST_EXT;
                end else begin
                    pay_len = {57'd0, b[6:0]};
                    length_known();
                end
            end
            ST_EXT: begin
                pay_len  = {pay_len[55:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0)
                    length_known();
            end
            ST_KEY: begin
                key      = {key[23:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0)
                    header_check();
            end
            ST_PAYLOAD: begin
                // first key byte sits in the top lane
                lane = 3 - int'(idx[1:0]);
                d    = b ^ key[8*lane +: 8];
                idx  = idx + 24'd1;
                if ({40'd0, idx} >= pay_len) begin
                    push_word(KIND_PAYLOAD, d, pay_len, 1'b1);
                    if (opc == OPC_CLOSE)
                        closed = 1'b1;
                    st = ST_HDR0;
                end else begin
                    push_word(KIND_PAYLOAD, d, pay_len, 1'b0);
                end
            end
            default: st = ST_HDR0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            st       = ST_HDR0;
            ext_left = '0;
            pay_len  = '0;
            masked   = 1'b0;
            key      = '0;
            idx      = '0;
            opc      = '0;
            hdr_len  = '0;
            closed   = 1'b0;
            limit    = MAX_FRAME_RESET;
            due_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                limit = i_cfg.max_frame_bytes;
            if (i_res.valid && i_res.ready) begin
                if (due_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected word kind %0d data %02h opc %h len %0d last %b",
                                 $realtime, i_res.kind, i_res.data, i_res.frame_opcode,
                                 i_res.frame_length, i_res.last);
                end else begin
                    want = due_q.pop_front();
                    if (i_res.kind !== want.kind || i_res.data !== want.data ||
                        i_res.frame_opcode !== want.frame_opcode ||
                        i_res.frame_length !== want.frame_length ||
                        i_res.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp kind %0d data %02h opc %h len %0d last %b, got kind %0d data %02h opc %h len %0d last %b",
                                     $realtime, want.kind, want.data, want.frame_opcode,
                                     want.frame_length, want.last, i_res.kind, i_res.data,
                                     i_res.frame_opcode, i_res.frame_length, i_res.last);
                    end
                end
            end
            if (i_rx.valid && i_rx.ready)
                deframe_byte(i_rx.rx_byte);
        end
        o_pending = due_q.size();
    end

endmodule

// ===== tb/websocket_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_tb
// Feeds directed and random WebSocket frames with random idling on both
// sides, rewrites the frame size limit between phases and ends the stream
// with a too-large error or a close frame, after which bytes are dropped.
// ----------------------------------------------------------------------------
module websocket_frame_parser_tb;
    import wsfp_pkg::*;

    localparam int ITEMS          = 1650;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {FORM_7, FORM_16, FORM_64} t_len_form;
    typedef enum int {END_HUGE, END_OVER, END_BELOW_MIN, END_CLOSE, END_CLOSE_EMPTY} t_ending;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsfp_byte_if rx_if();
    wsfp_res_if  res_if();
    wsfp_cfg_if  cfg_if();

    int   fail_count;
    int   pending;
    int   bytes_sent;
    int   idle_cycles;
    bit   rx_gaps;
    bit   res_stalls;
    bit   hold_req;
    t_len cur_limit;

    websocket_frame_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    websocket_frame_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // no word moved for too long
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, and one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (res_stalls && $urandom_range(0, 7) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input t_byte b);
        if (rx_gaps && $urandom_range(0, 7) == 0) begin
            rx_if.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge i_clk); while (!rx_if.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_payload(input int n, input int fill);
        repeat (n) send_byte((fill < 0) ? t_byte'($urandom_range(0, 255)) : t_byte'(fill));
    endtask

    // header byte 1, extended length and mask key
    task automatic send_length(input bit m, input logic [63:0] len, input t_len_form form);
        case (form)
            FORM_7: send_byte({m, len[6:0]});
            FORM_16: begin
                send_byte({m, LEN_ESC16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({m, LEN_ESC64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
        if (m)
            send_payload(4, -1);
    endtask

    task automatic send_header(input t_opcode op, input bit m, input logic [63:0] len,
                               input t_len_form form);
        // FIN and RSV bits are not checked, so they stay random
        send_byte({4'($urandom_range(0, 15)), op});
        send_length(m, len, form);
    endtask

    function automatic int hdr_size(bit m, t_len_form form);
        return 2 + ((form == FORM_16) ? 2 : (form == FORM_64) ? 8 : 0) + (m ? 4 : 0);
    endfunction

    task automatic wait_idle();
        rx_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_limit(input t_len v);
        wait_idle();
        cfg_if.valid           = 1'b1;
        cfg_if.max_frame_bytes = v;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        cur_limit    = v;
    endtask

    // well-formed frame that fits the limit, never a close frame
    task automatic random_frame();
        t_len_form form;
        bit        m;
        int        hs;
        int        n;
        int        pick;
        t_opcode   op;
        pick = $urandom_range(0, 9);
        form = (pick < 6) ? FORM_7 : (pick < 9) ? FORM_16 : FORM_64;
        m    = $urandom_range(0, 1);
        hs   = hdr_size(m, form);
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, (form == FORM_7) ? 125 : 400);
        else
            n = $urandom_range(0, 16);
        if (hs + n > int'(cur_limit))
            n = int'(cur_limit) - hs;
        op = 4'($urandom_range(0, 15));
        if (op == OPC_CLOSE)
            op = op ^ 4'h1;
        send_header(op, m, 64'(n), form);
        send_payload(n, -1);
    endtask

    task automatic run_frames(input int upto);
        while (bytes_sent < upto)
            random_frame();
    endtask

    initial begin
        t_ending     ending;
        bit          m;
        logic [63:0] big;
        i_rst_n                = 1'b0;
        rx_if.valid            = 1'b0;
        rx_if.rx_byte          = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.max_frame_bytes = MAX_FRAME_RESET;
        rx_gaps                = 1'b1;
        res_stalls             = 1'b1;
        cur_limit              = MAX_FRAME_RESET;
        bytes_sent             = 0;
        idle_cycles            = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty text frame, masked ping of all ones, 16-bit length with a zero byte
        send_header(4'h1, 1'b0, 64'd0, FORM_7);
        send_header(4'h9, 1'b1, 64'd2, FORM_7);
        send_payload(2, 8'hFF);
        send_header(4'h2, 1'b0, 64'd1, FORM_16);
        send_payload(1, 8'h00);
        // limit drops to its minimum between header bytes; the 14-byte header
        // of a masked empty frame then sits exactly on the limit
        send_byte({4'h8, 4'hA});
        set_limit(24'd14);
        send_length(1'b1, 64'd0, FORM_64);

        run_frames(350);

        rx_gaps    = 1'b0;
        res_stalls = 1'b0;
        set_limit(LEN_MAX);
        run_frames(650);

        rx_gaps    = 1'b1;
        res_stalls = 1'b1;
        set_limit(t_len'($urandom_range(100, 600)));
        hold_req = 1'b1;
        send_header(4'h2, 1'b1, 64'd60, FORM_16);
        send_payload(60, -1);
        run_frames(1000);

        set_limit(MAX_FRAME_RESET);
        run_frames(1350);

        rx_gaps    = 1'b0;
        res_stalls = 1'b0;
        set_limit(t_len'($urandom_range(14, 2000)));
        run_frames(ITEMS - 40);

        // the stream closes once, so the ending is picked at random
        ending = t_ending'($urandom_range(0, 4));
        m      = $urandom_range(0, 1);
        case (ending)
            END_HUGE: begin
                big = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
                send_header(4'h1, m, big, FORM_64);
            end
            END_OVER: send_header(4'h2, m, 64'(int'(cur_limit) - hdr_size(m, FORM_16) + 1),
                                  FORM_16);
            END_BELOW_MIN: begin
                set_limit(t_len'($urandom_range(0, 13)));
                send_header(4'h1, 1'b1, 64'd0, FORM_64);
            end
            END_CLOSE: begin
                send_header(OPC_CLOSE, m, 64'd5, FORM_7);
                send_payload(5, -1);
            end
            default: send_header(OPC_CLOSE, m, 64'd0, FORM_7);
        endcase
        // everything from here on is dropped
        send_header(4'h1, 1'b0, 64'd3, FORM_7);
        send_payload(16, -1);

        rx_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
